### sv/aab_pkg.sv
package aab_pkg;

  localparam int GainW   = 17;
  localparam int LimitW  = 31;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 31;
  localparam int WordW   = 32;
  localparam int ResW    = 33;
  localparam int ProdW   = 66;
  localparam int SumW    = 52;
  localparam int NumW    = 50;
  localparam int CntW    = 6;

  localparam logic [CfgIdxW-1:0] REG_POSITION_GAIN  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PLAIN_VEL_GAIN = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_FAST_VEL_GAIN  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SLOW_VEL_GAIN  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RESIDUAL_LIMIT = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ADAPTIVE_EN    = 3'd5;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_REINIT = 1'b1;

  typedef struct packed {
    logic load;
    logic reinit;
    logic mul_vdt;
    logic pred;
    logic mul_alpha;
    logic pos;
    logic mul_gain;
    logic div_init;
    logic div_step;
    logic vel;
    logic emit;
    logic changed;
  } aab_cmd_t;

  typedef struct packed {
    logic is_reinit;
    logic dt_pos;
  } aab_status_t;

  function automatic logic [WordW-1:0] sat32(input logic [SumW-1:0] s);
    logic [WordW-1:0] r;
    if ((&s[SumW-1:WordW-1]) || !(|s[SumW-1:WordW-1])) begin
      r = s[WordW-1:0];
    end else if (s[SumW-1]) begin
      r = {1'b1, {(WordW-1){1'b0}}};
    end else begin
      r = {1'b0, {(WordW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

### sv/aab_ctrl.sv
module aab_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  aab_pkg::aab_status_t status,
  output aab_pkg::aab_cmd_t    cmd
);
  import aab_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECIDE  = 4'd1;
  localparam logic [3:0] S_MVDT    = 4'd2;
  localparam logic [3:0] S_PRED    = 4'd3;
  localparam logic [3:0] S_MALPHA  = 4'd4;
  localparam logic [3:0] S_POS     = 4'd5;
  localparam logic [3:0] S_MGAIN   = 4'd6;
  localparam logic [3:0] S_DIVINIT = 4'd7;
  localparam logic [3:0] S_DIV     = 4'd8;
  localparam logic [3:0] S_VEL     = 4'd9;
  localparam logic [3:0] S_DONE    = 4'd10;

  logic [3:0]      state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            chg_r, chg_nxt;
  logic            ovalid_r, ovalid_nxt;
  logic            emit_ok;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign emit_ok    = !ovalid_r || out_tready;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    chg_nxt    = chg_r;
    ovalid_nxt = ovalid_r && !out_tready;
    cmd        = '0;
    cmd.changed = chg_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (status.is_reinit) begin
          cmd.reinit = 1'b1;
          chg_nxt    = 1'b1;
          state_nxt  = S_DONE;
        end else if (status.dt_pos) begin
          chg_nxt    = 1'b1;
          state_nxt  = S_MVDT;
        end else begin
          chg_nxt    = 1'b0;
          state_nxt  = S_DONE;
        end
      end
      S_MVDT: begin
        cmd.mul_vdt = 1'b1;
        state_nxt   = S_PRED;
      end
      S_PRED: begin
        cmd.pred  = 1'b1;
        state_nxt = S_MALPHA;
      end
      S_MALPHA: begin
        cmd.mul_alpha = 1'b1;
        state_nxt     = S_POS;
      end
      S_POS: begin
        cmd.pos   = 1'b1;
        state_nxt = S_MGAIN;
      end
      S_MGAIN: begin
        cmd.mul_gain = 1'b1;
        state_nxt    = S_DIVINIT;
      end
      S_DIVINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CntW'(NumW - 1)) begin
          state_nxt = S_VEL;
        end
      end
      S_VEL: begin
        cmd.vel   = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (emit_ok) begin
          cmd.emit   = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      chg_r    <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      chg_r    <= chg_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

### sv/aab_dp.sv
module aab_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [aab_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [aab_pkg::CfgW-1:0]    cfg_data,
  input  logic                        in_command,
  input  logic [aab_pkg::WordW-1:0]   in_measurement,
  input  logic [aab_pkg::WordW-1:0]   in_time_step,
  input  aab_pkg::aab_cmd_t           cmd,
  output aab_pkg::aab_status_t        status,
  output logic [aab_pkg::WordW-1:0]   out_position,
  output logic [aab_pkg::WordW-1:0]   out_velocity,
  output logic                        out_changed
);
  import aab_pkg::*;

  logic [GainW-1:0]  alpha_r, beta_plain_r, beta_fast_r, beta_slow_r, gain_r;
  logic [LimitW-1:0] limit_r;
  logic              adapt_r;

  logic              cmd_r;
  logic [WordW-1:0]  meas_r, dt_r;
  logic [WordW-1:0]  x_r, v_r, x_nxt, v_nxt;
  logic [WordW-1:0]  pred_r;
  logic [ResW-1:0]   res_r;
  logic signed [ProdW-1:0] prod_r;
  logic signed [ResW-1:0]  op_a, op_b;
  logic [NumW-1:0]   num_r;
  logic [WordW-2:0]  rem_r;
  logic              neg_r;

  logic [SumW-1:0]   pred_sum, pos_sum, vel_sum;
  logic [WordW-1:0]  pred_nxt;
  logic [ResW-1:0]   mag;
  logic [ProdW-1:0]  prod_mag;
  logic [WordW-1:0]  trial;
  logic              fits;
  logic [NumW:0]     quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r      <= '0;
      beta_plain_r <= '0;
      beta_fast_r  <= '0;
      beta_slow_r  <= '0;
      limit_r      <= '0;
      adapt_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POSITION_GAIN:  alpha_r      <= cfg_data[GainW-1:0];
        REG_PLAIN_VEL_GAIN: beta_plain_r <= cfg_data[GainW-1:0];
        REG_FAST_VEL_GAIN:  beta_fast_r  <= cfg_data[GainW-1:0];
        REG_SLOW_VEL_GAIN:  beta_slow_r  <= cfg_data[GainW-1:0];
        REG_RESIDUAL_LIMIT: limit_r      <= cfg_data[LimitW-1:0];
        REG_ADAPTIVE_EN:    adapt_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign status.is_reinit = (cmd_r == CMD_REINIT);
  assign status.dt_pos    = !dt_r[WordW-1] && (|dt_r);

  always_comb begin
    op_a = {v_r[WordW-1], v_r};
    op_b = {dt_r[WordW-1], dt_r};
    if (cmd.mul_alpha) begin
      op_a = {{(ResW-GainW){1'b0}}, alpha_r};
      op_b = res_r;
    end else if (cmd.mul_gain) begin
      op_a = {{(ResW-GainW){1'b0}}, gain_r};
      op_b = res_r;
    end
  end

  assign pred_sum = {{(SumW-WordW){x_r[WordW-1]}}, x_r}
                  + {{(SumW-48){prod_r[63]}}, prod_r[63:16]};
  assign pred_nxt = sat32(pred_sum);
  assign pos_sum  = {{(SumW-WordW){pred_r[WordW-1]}}, pred_r}
                  + {{(SumW-50){prod_r[ProdW-1]}}, prod_r[ProdW-1:16]};
  assign mag      = res_r[ResW-1] ? (~res_r + 1'b1) : res_r;
  assign prod_mag = prod_r[ProdW-1] ? (~prod_r + 1'b1) : prod_r;
  assign trial    = {rem_r, num_r[NumW-1]};
  assign fits     = trial >= {1'b0, dt_r[WordW-2:0]};
  assign quo      = neg_r ? (~{1'b0, num_r} + 1'b1) : {1'b0, num_r};
  assign vel_sum  = {{(SumW-WordW){v_r[WordW-1]}}, v_r}
                  + {{(SumW-NumW-1){quo[NumW]}}, quo};

  always_comb begin
    x_nxt = x_r;
    v_nxt = v_r;
    if (cmd.reinit) begin
      x_nxt = meas_r;
      v_nxt = '0;
    end else if (cmd.pos) begin
      x_nxt = sat32(pos_sum);
    end else if (cmd.vel) begin
      v_nxt = sat32(vel_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      v_r <= '0;
    end else begin
      x_r <= x_nxt;
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_command;
      meas_r <= in_measurement;
      dt_r   <= in_time_step;
    end
    if (cmd.mul_vdt || cmd.mul_alpha || cmd.mul_gain) begin
      prod_r <= op_a * op_b;
    end
    if (cmd.pred) begin
      pred_r <= pred_nxt;
      res_r  <= {meas_r[WordW-1], meas_r} - {pred_nxt[WordW-1], pred_nxt};
    end
    if (cmd.pos) begin
      if (!adapt_r) begin
        gain_r <= beta_plain_r;
      end else if (mag > {2'b00, limit_r}) begin
        gain_r <= beta_fast_r;
      end else begin
        gain_r <= beta_slow_r;
      end
    end
    if (cmd.div_init) begin
      neg_r <= prod_r[ProdW-1];
      num_r <= prod_mag[NumW-1:0];
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= fits ? (trial[WordW-2:0] - dt_r[WordW-2:0]) : trial[WordW-2:0];
      num_r <= {num_r[NumW-2:0], fits};
    end
    if (cmd.emit) begin
      out_position <= x_r;
      out_velocity <= v_r;
      out_changed  <= cmd.changed;
    end
  end

endmodule

### sv/adaptive_alpha_beta_filter.sv
// Alpha-beta tracker, Q16.16 state, Q1.16 gains. One item is worked at a time:
// the work of an update with a positive time step lies mostly in the 50-step
// bit-serial divider that forms gain*residual/dt; a reinitialize or a skipped
// update goes from the decide state straight to the result. The three products
// share one 33x33 multiplier. The result sits in an output register, so the
// next item is taken while it waits.
module adaptive_alpha_beta_filter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [aab_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [aab_pkg::CfgW-1:0]    cfg_data,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [63:0]                 in_tdata,   // measurement, time_step
  input  logic                        in_tuser,   // command
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [63:0]                 out_tdata,  // position_estimate, velocity_estimate
  output logic                        out_tuser   // state_changed
);
  import aab_pkg::*;

  aab_cmd_t    cmd;
  aab_status_t status;

  aab_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  aab_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_command     (in_tuser),
    .in_measurement (in_tdata[31:0]),
    .in_time_step   (in_tdata[63:32]),
    .cmd            (cmd),
    .status         (status),
    .out_position   (out_tdata[31:0]),
    .out_velocity   (out_tdata[63:32]),
    .out_changed    (out_tuser)
  );

endmodule

### sv/aab_checker.sv
module aab_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [63:0] in_tdata,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tuser
);
  import aab_pkg::*;

  logic in_xfer;
  assign in_xfer = in_tvalid && in_tready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("second item taken while busy");

  a_reinit: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tuser == CMD_REINIT && !out_tvalid |-> ##3
      out_tvalid && out_tuser && out_tdata[31:0] == $past(in_tdata[31:0], 3)
      && out_tdata[63:32] == 32'd0)
    else $error("reinitialize result wrong");

  a_skip: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tuser == CMD_UPDATE && (in_tdata[63] || in_tdata[63:32] == 32'd0)
      && !out_tvalid |-> ##3 out_tvalid && !out_tuser)
    else $error("skipped update flagged as changed");

endmodule

bind adaptive_alpha_beta_filter aab_checker u_aab_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import aab_pkg::*;

  localparam int  RAND_PHASES    = 8;
  localparam int  ITEMS_PER_PHASE = 180;
  localparam int  HOLD_CYCLES    = 400;
  localparam int  DRAIN_CYCLES   = 80;
  localparam int  LIMIT_CYCLES   = 1000000;
  localparam int  PRINT_CAP      = 200;
  localparam longint WORD_MAX    = 64'sd2147483647;
  localparam longint WORD_MIN    = -64'sd2147483648;

  // indexes past the register list; writes there must be dropped
  localparam logic [CfgIdxW-1:0] REG_UNMAPPED_A = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_UNMAPPED_B = 3'd7;

  typedef enum logic [1:0] {K_ITEM, K_CHECK, K_CFG} row_kind_t;
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [31:0] pos;
    logic [31:0] vel;
    logic        chg;
  } filt_res_t;

  // cfg rows carry the write data in data
  typedef struct packed {
    row_kind_t           kind;
    logic                cmd;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [31:0]         data;
    logic [31:0]         step;
    logic [31:0]         exp_pos;
    logic [31:0]         exp_vel;
    logic                exp_chg;
  } stim_row_t;

  localparam int NROWS = 30;

  stim_row_t dir_tab [NROWS] = '{
    '{K_CHECK, CMD_UPDATE, '0, 32'h7fffffff, 32'h00000001, 32'h0, 32'h0, 1'b1},
    '{K_CHECK, CMD_UPDATE, '0, 32'hffffffff, 32'h00000000, 32'h0, 32'h0, 1'b0},
    '{K_CHECK, CMD_UPDATE, '0, 32'h00000005, 32'h80000000, 32'h0, 32'h0, 1'b0},
    '{K_CHECK, CMD_REINIT, '0, 32'h80000000, 32'h00000000, 32'h80000000, 32'h0, 1'b1},
    '{K_CHECK, CMD_REINIT, '0, 32'h7fffffff, 32'hffffffff, 32'h7fffffff, 32'h0, 1'b1},
    '{K_CHECK, CMD_UPDATE, '0, 32'h00000000, 32'hffff0000, 32'h7fffffff, 32'h0, 1'b0},
    '{K_CFG, '0, REG_POSITION_GAIN, 32'h00010000, '0, '0, '0, '0},
    '{K_CFG, '0, REG_PLAIN_VEL_GAIN, 32'h00010000, '0, '0, '0, '0},
    '{K_CFG, '0, REG_ADAPTIVE_EN, 32'h00000000, '0, '0, '0, '0},
    '{K_ITEM, CMD_UPDATE, '0, 32'h80000000, 32'h00000001, '0, '0, '0},
    '{K_ITEM, CMD_UPDATE, '0, 32'h7fffffff, 32'h7fffffff, '0, '0, '0},
    '{K_ITEM, CMD_UPDATE, '0, 32'h00003039, 32'h00010000, '0, '0, '0},
    '{K_CFG, '0, REG_POSITION_GAIN, 32'h7fffffff, '0, '0, '0, '0},
    '{K_CFG, '0, REG_FAST_VEL_GAIN, 32'h0001ffff, '0, '0, '0, '0},
    '{K_CFG, '0, REG_SLOW_VEL_GAIN, 32'h00000001, '0, '0, '0, '0},
    '{K_CFG, '0, REG_RESIDUAL_LIMIT, 32'h7fffffff, '0, '0, '0, '0},
    '{K_CFG, '0, REG_ADAPTIVE_EN, 32'h00000001, '0, '0, '0, '0},
    '{K_CHECK, CMD_REINIT, '0, 32'h00000000, 32'h00000000, 32'h0, 32'h0, 1'b1},
    '{K_ITEM, CMD_UPDATE, '0, 32'h7fffffff, 32'h00010000, '0, '0, '0},
    '{K_ITEM, CMD_UPDATE, '0, 32'h80000000, 32'h00000001, '0, '0, '0},
    '{K_CFG, '0, REG_RESIDUAL_LIMIT, 32'h00000000, '0, '0, '0, '0},
    '{K_CFG, '0, REG_UNMAPPED_A, 32'h00000055, '0, '0, '0, '0},
    '{K_CFG, '0, REG_UNMAPPED_B, 32'h7fffffff, '0, '0, '0, '0},
    '{K_ITEM, CMD_UPDATE, '0, 32'h00000000, 32'h00010000, '0, '0, '0},
    '{K_ITEM, CMD_UPDATE, '0, 32'h00000001, 32'h00000003, '0, '0, '0},
    '{K_CHECK, CMD_REINIT, '0, 32'hffff0000, 32'h7fffffff, 32'hffff0000, 32'h0, 1'b1},
    '{K_CHECK, CMD_UPDATE, '0, 32'hffff0000, 32'h00000000, 32'hffff0000, 32'h0, 1'b0},
    '{K_ITEM, CMD_UPDATE, '0, 32'hffff0000, 32'h00010000, '0, '0, '0},
    '{K_ITEM, CMD_UPDATE, '0, 32'h00640000, 32'h00008000, '0, '0, '0},
    '{K_ITEM, CMD_UPDATE, '0, 32'hfff00000, 32'h00000100, '0, '0, '0}
  };

  // indexed by idle_mode_t: none, send, recv, both
  int send_pct [4] = '{0, 66, 0, 29};
  int stall_pct [4] = '{0, 0, 66, 29};

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgW-1:0]     cfg_data;
  logic                in_tvalid;
  logic                in_tready;
  logic [63:0]         in_tdata;   // measurement, time_step
  logic                in_tuser;   // command
  logic                out_tvalid;
  logic                out_tready;
  logic [63:0]         out_tdata;  // position_estimate, velocity_estimate
  logic                out_tuser;  // state_changed

  // tracker state and register copies
  logic signed [31:0]  trk_pos;
  logic signed [31:0]  trk_vel;
  logic [16:0]         trk_alpha;
  logic [16:0]         trk_plain;
  logic [16:0]         trk_fast;
  logic [16:0]         trk_slow;
  logic [30:0]         trk_limit;
  logic                trk_adapt;

  filt_res_t  track_q [$];
  int         err_count = 0;
  int         cycle_count = 0;
  idle_mode_t idle_mode;
  int         hold_reqs = 0;

  adaptive_alpha_beta_filter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint clamp32(input longint s);
    if (s > WORD_MAX) return WORD_MAX;
    if (s < WORD_MIN) return WORD_MIN;
    return s;
  endfunction

  function automatic filt_res_t track_step(input logic cmd, input logic signed [31:0] meas,
                                           input logic signed [31:0] step);
    longint x, v, m, d, pred, res, mag, gain, alpha, lim, nx, nv;
    filt_res_t r;
    x = trk_pos;
    v = trk_vel;
    m = meas;
    d = step;
    alpha = trk_alpha;
    lim = trk_limit;
    r.chg = 1'b0;
    if (cmd == CMD_REINIT) begin
      trk_pos = meas;
      trk_vel = '0;
      r.chg = 1'b1;
    end else if (d > 0) begin
      pred = clamp32(x + ((v * d) >>> 16));
      res = m - pred;
      mag = (res < 0) ? -res : res;
      if (trk_adapt) begin
        gain = (mag > lim) ? longint'(trk_fast) : longint'(trk_slow);
      end else begin
        gain = trk_plain;
      end
      nx = clamp32(pred + ((alpha * res) >>> 16));
      nv = clamp32(v + (gain * res) / d);
      trk_pos = nx[31:0];
      trk_vel = nv[31:0];
      r.chg = 1'b1;
    end
    r.pos = trk_pos;
    r.vel = trk_vel;
    return r;
  endfunction

  function automatic int sender_gap();
    int g = 0;
    int pct;
    pct = send_pct[idle_mode];
    if (pct == 0) return 0;
    if ($urandom_range(15) == 0) return $urandom_range(80, 1);
    while (g < 20 && $urandom_range(99) < pct) g++;
    return g;
  endfunction

  function automatic logic [30:0] pick_gain();
    case ($urandom_range(5))
      0: return '0;
      1: return 31'd65536;
      2: return 31'($urandom);
      default: return 31'($urandom_range(65536));
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < PRINT_CAP) $display("mismatch @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [30:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_POSITION_GAIN:  trk_alpha = val[16:0];
      REG_PLAIN_VEL_GAIN: trk_plain = val[16:0];
      REG_FAST_VEL_GAIN:  trk_fast  = val[16:0];
      REG_SLOW_VEL_GAIN:  trk_slow  = val[16:0];
      REG_RESIDUAL_LIMIT: trk_limit = val;
      REG_ADAPTIVE_EN:    trk_adapt = val[0];
      default: ;
    endcase
  endtask

  task automatic cfg_release();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // stop offering and wait for every expected result
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (track_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_item(input logic cmd, input logic [31:0] meas, input logic [31:0] step,
                           input logic typed, input filt_res_t typed_res);
    int gap;
    filt_res_t want;
    gap = sender_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {step, meas};
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    want = track_step(cmd, meas, step);
    track_q.push_back(typed ? typed_res : want);
  endtask

  initial begin : result_sink
    int hold_left;
    int hold_done;
    hold_left = 0;
    hold_done = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_done) begin
        hold_done = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct[idle_mode]);
      end
    end
  end

  always @(posedge clk) begin : result_check
    filt_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (track_q.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want = track_q.pop_front();
        if (out_tdata[31:0] !== want.pos)
          report_mismatch($sformatf("position %h, want %h", out_tdata[31:0], want.pos));
        if (out_tdata[63:32] !== want.vel)
          report_mismatch($sformatf("velocity %h, want %h", out_tdata[63:32], want.vel));
        if (out_tuser !== want.chg)
          report_mismatch($sformatf("state_changed %b, want %b", out_tuser, want.chg));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin : stim
    stim_row_t   row;
    filt_res_t   typed_res;
    bit          cfg_open;
    logic        cmd;
    logic [31:0] meas, step, span;
    longint      base;
    int          sel;

    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = CMD_UPDATE;
    trk_pos     = '0;
    trk_vel     = '0;
    trk_alpha   = '0;
    trk_plain   = '0;
    trk_fast    = '0;
    trk_slow    = '0;
    trk_limit   = '0;
    trk_adapt   = 1'b0;
    idle_mode   = IDLE_NONE;
    cfg_open    = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[r]) begin
      row = dir_tab[r];
      if (row.kind == K_CFG) begin
        if (!cfg_open) begin
          settle();
          cfg_open = 1'b1;
        end
        cfg_write(row.reg_idx, row.data[30:0]);
      end else begin
        if (cfg_open) begin
          cfg_release();
          cfg_open = 1'b0;
        end
        typed_res = '{pos: row.exp_pos, vel: row.exp_vel, chg: row.exp_chg};
        send_item(row.cmd, row.data, row.step, row.kind == K_CHECK, typed_res);
      end
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      settle();
      cfg_write(REG_POSITION_GAIN, pick_gain());
      cfg_write(REG_PLAIN_VEL_GAIN, pick_gain());
      cfg_write(REG_FAST_VEL_GAIN, pick_gain());
      cfg_write(REG_SLOW_VEL_GAIN, pick_gain());
      cfg_write(REG_RESIDUAL_LIMIT, (p == 2) ? 31'd0 : (p == 3) ? '1 :
                31'($urandom) >> $urandom_range(30));
      cfg_write(REG_ADAPTIVE_EN, 31'($urandom));
      cfg_write($urandom_range(1) ? REG_UNMAPPED_A : REG_UNMAPPED_B, 31'($urandom));
      cfg_release();
      idle_mode = idle_mode_t'(p % 4);
      if (p == 1 || p == 6) hold_reqs++;

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        sel  = $urandom_range(99);
        cmd  = CMD_UPDATE;
        meas = $urandom;
        step = $urandom;
        if (sel < 5) begin
          cmd = CMD_REINIT;
        end else if (sel < 10) begin
          step = (sel < 7) ? 32'h0 : (step | 32'h80000000);
        end else if (sel >= 20) begin
          // track a target near the predicted position
          step = (step & (32'h7fffffff >> $urandom_range(30, 4))) | 32'h1;
          base = clamp32(longint'(trk_pos) + ((longint'(trk_vel) * longint'(step)) >>> 16));
          span = 32'hffffffff >> $urandom_range(31, 1);
          meas = base[31:0] + (meas & span) - (span >> 1);
        end
        send_item(cmd, meas, step, 1'b0, '0);
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
sv/aab_pkg.sv
sv/aab_ctrl.sv
sv/aab_dp.sv
sv/adaptive_alpha_beta_filter.sv
sv/aab_checker.sv
verif/tb.sv
